### rtl/core/xsp_pkg.sv
// Shared types and constants for the xorshift128+ generator with splitmix64 seeding.
package xsp_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;

  localparam logic [WordW-1:0] MixGamma = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [WordW-1:0] MixMul1  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [WordW-1:0] MixMul2  = 64'h94d0_49bb_1331_11eb;

  localparam int unsigned XsShiftA = 23;
  localparam int unsigned XsShiftB = 18;
  localparam int unsigned XsShiftC = 5;
  localparam int unsigned MixShiftA = 30;
  localparam int unsigned MixShiftB = 27;
  localparam int unsigned MixShiftC = 31;

  typedef enum logic [1:0] {
    KIND_DRAW64 = 2'd0,
    KIND_DRAW32 = 2'd1,
    KIND_SEED   = 2'd2,
    KIND_LOAD   = 2'd3
  } kind_e;

  // Operand pair for the shared 32x32 multiplier.
  typedef struct packed {
    logic [HalfW-1:0] a;
    logic [HalfW-1:0] b;
  } mul_req_t;

endpackage

### rtl/core/xorshift128plus_prng_splitmix_seed_top.sv
// Top level of the xorshift128+ generator with splitmix64 seeding.
//
//   channel | signals                                     | direction
//   --------+---------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, kind_i, seed_i,     | to block
//           | load_word0_i, load_word1_i                  |
//   out     | out_valid_o, out_ready_i, value_o, error_o  | from block
//
// Draws and loads finish in the cycle that accepts them: the result is registered
// into the output register, and a new item can be taken in the next cycle while
// the output register is empty or being read. A seed runs two splitmix64 rounds
// through one shared 32x32 multiplier; each round is a counter step followed by
// two 64-bit multiplications, and the seed's item reaches the output after its second round.
// Reset clears both state words to zero, so draws before any seed or load return zero.
// The input is held off while a seed runs or while a result waits unaccepted.
module xorshift128plus_prng_splitmix_seed_top
  import xsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       kind_i,
  input  logic [WordW-1:0] seed_i,
  input  logic [WordW-1:0] load_word0_i,
  input  logic [WordW-1:0] load_word1_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WordW-1:0] value_o,
  output logic             error_o
);

  // The sequencer idles, steps the splitmix counter, or walks the multiplier.
  typedef enum logic [1:0] {
    S_IDLE,
    S_PRE,
    S_MUL
  } state_e;

  state_e           state_q, state_d;
  logic [WordW-1:0] s0_q, s0_d, s1_q, s1_d;
  logic [WordW-1:0] ctr_q, ctr_d;
  logic [WordW-1:0] z_q, z_d;
  logic [WordW-1:0] acc_q, acc_d;
  logic [1:0]       ph_q, ph_d;
  logic             pass_q, pass_d;
  logic             word_q, word_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] value_q, value_d;
  logic             error_q, error_d;

  logic             in_acc;
  logic [WordW-1:0] sum;
  logic [WordW-1:0] xa;
  logic [WordW-1:0] nxt1;
  logic [WordW-1:0] ctr_inc;
  logic [WordW-1:0] mul_k;
  logic [WordW-1:0] z_new;
  logic [WordW-1:0] prod;
  mul_req_t         mreq;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  // One xorshift128+ step on the current state words.
  assign sum  = s0_q + s1_q;
  assign xa   = s0_q ^ (s0_q << XsShiftA);
  assign nxt1 = xa ^ s1_q ^ (xa >> XsShiftB) ^ (s1_q >> XsShiftC);

  assign ctr_inc = ctr_q + MixGamma;

  // The first multiplication of a round uses the first constant, the second the other.
  assign mul_k = pass_q ? MixMul2 : MixMul1;
  assign z_new = acc_q + {prod[HalfW-1:0], {HalfW{1'b0}}};

  // Partial products: low x low, low x high, then high x low.
  always_comb begin
    case (ph_q)
      2'd0:    mreq = '{a: z_q[HalfW-1:0], b: mul_k[HalfW-1:0]};
      2'd1:    mreq = '{a: z_q[HalfW-1:0], b: mul_k[WordW-1:HalfW]};
      default: mreq = '{a: z_q[WordW-1:HalfW], b: mul_k[HalfW-1:0]};
    endcase
  end

  xsp_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .prod_o (prod)
  );

  always_comb begin
    state_d     = state_q;
    s0_d        = s0_q;
    s1_d        = s1_q;
    ctr_d       = ctr_q;
    z_d         = z_q;
    acc_d       = acc_q;
    ph_d        = ph_q;
    pass_d      = pass_q;
    word_d      = word_q;
    out_valid_d = out_valid_q;
    value_d     = value_q;
    error_d     = error_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          value_d = '0;
          error_d = 1'b0;
          case (kind_e'(kind_i))
            KIND_DRAW64: begin
              s0_d        = s1_q;
              s1_d        = nxt1;
              value_d     = sum;
              out_valid_d = 1'b1;
            end
            KIND_DRAW32: begin
              s0_d        = s1_q;
              s1_d        = nxt1;
              value_d     = {{HalfW{1'b0}}, sum[HalfW-1:0]};
              out_valid_d = 1'b1;
            end
            KIND_SEED: begin
              ctr_d   = seed_i;
              word_d  = 1'b0;
              state_d = S_PRE;
            end
            default: begin
              s0_d        = load_word0_i;
              s1_d        = load_word1_i;
              error_d     = (load_word0_i == '0) && (load_word1_i == '0);
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_PRE: begin
        ctr_d   = ctr_inc;
        z_d     = ctr_inc ^ (ctr_inc >> MixShiftA);
        ph_d    = 2'd0;
        pass_d  = 1'b0;
        state_d = S_MUL;
      end
      S_MUL: begin
        ph_d = ph_q + 2'd1;
        case (ph_q)
          2'd0: ;
          2'd1: acc_d = prod;
          2'd2: acc_d = z_new;
          default: begin
            if (!pass_q) begin
              z_d    = z_new ^ (z_new >> MixShiftB);
              pass_d = 1'b1;
            end else if (!word_q) begin
              s0_d    = z_new ^ (z_new >> MixShiftC);
              word_d  = 1'b1;
              state_d = S_PRE;
            end else begin
              s1_d        = z_new ^ (z_new >> MixShiftC);
              out_valid_d = 1'b1;
              state_d     = S_IDLE;
            end
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      s0_q        <= '0;
      s1_q        <= '0;
      ph_q        <= 2'd0;
      pass_q      <= 1'b0;
      word_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      s0_q        <= s0_d;
      s1_q        <= s1_d;
      ph_q        <= ph_d;
      pass_q      <= pass_d;
      word_q      <= word_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    ctr_q   <= ctr_d;
    z_q     <= z_d;
    acc_q   <= acc_d;
    value_q <= value_d;
    error_q <= error_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign error_o     = error_q;

  // A seed holds the output empty until its last round completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !out_valid_q)
    else $error("output valid while a seed is running");

  // An accepted seed starts the counter step next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (kind_i == KIND_SEED)) |=> (state_q == S_PRE))
    else $error("seed did not start the splitmix sequence");

  // The error flag only comes with a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && error_q) |-> (value_q == '0))
    else $error("error raised with a nonzero value");

  // An accepted zero load leaves both state words zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (kind_i == KIND_LOAD) && (load_word0_i == '0) && (load_word1_i == '0))
      |=> (s0_q == '0) && (s1_q == '0) && error_q)
    else $error("zero load not reflected in state or flag");

endmodule

### rtl/core/xsp_mul.sv
// Shared 32x32 multiplier with a registered 64-bit product.
module xsp_mul
  import xsp_pkg::*;
(
  input  logic             clk_i,
  input  mul_req_t         req_i,
  output logic [WordW-1:0] prod_o
);

  logic [WordW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= WordW'(req_i.a) * WordW'(req_i.b);
  end

  assign prod_o = prod_q;

endmodule

### tb/sv/xorshift128plus_prng_splitmix_seed_top_test.sv
// Self-checking testbench for the xorshift128+ generator with splitmix64 seeding.
module xorshift128plus_prng_splitmix_seed_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import xsp_pkg::*;

  localparam int unsigned ClkHalf       = 6;
  localparam int unsigned ResetCycles   = 8;
  localparam int unsigned ItemsPerPhase = 417;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned DirectedRows  = 25;
  localparam logic [WordW-1:0] AllOnes  = {WordW{1'b1}};
  localparam logic [WordW-1:0] TopBit   = {1'b1, {(WordW-1){1'b0}}};

  // One input item as the generator sees it.
  typedef struct {
    kind_e            kind;
    logic [WordW-1:0] seed;
    logic [WordW-1:0] word0;
    logic [WordW-1:0] word1;
  } gen_item_t;

  // One result item.
  typedef struct {
    logic [WordW-1:0] value;
    logic             error;
  } gen_result_t;

  // A row of the directed table. When typed is set, the result in the row is the
  // expectation; otherwise the expectation comes from the generator model below.
  typedef struct {
    gen_item_t   item;
    bit          typed;
    gen_result_t result;
  } directed_row_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_ready_o;
  logic [1:0]       kind_i       = KIND_DRAW64;
  logic [WordW-1:0] seed_i       = '0;
  logic [WordW-1:0] load_word0_i = '0;
  logic [WordW-1:0] load_word1_i = '0;
  logic             out_valid_o;
  logic             out_ready_i  = 1'b0;
  logic [WordW-1:0] value_o;
  logic             error_o;

  // Model copy of the two generator state words; the block resets them to zero.
  logic [WordW-1:0] model_word0 = '0;
  logic [WordW-1:0] model_word1 = '0;

  // Results the block still owes us, oldest first.
  gen_result_t pending_results[$];

  // Percent of cycles in which the sender holds back and the receiver stalls.
  int unsigned send_idle_pct = 26;
  int unsigned recv_idle_pct = 63;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  xorshift128plus_prng_splitmix_seed_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .seed_i       (seed_i),
    .load_word0_i (load_word0_i),
    .load_word1_i (load_word1_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .error_o      (error_o)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Output half of the splitmix64 step: takes the already advanced counter and
  // scrambles it with two multiply and xor-shift rounds.
  function automatic logic [WordW-1:0] splitmix_scramble(input logic [WordW-1:0] ctr);
    logic [WordW-1:0] z;
    z = ctr;
    z = (z ^ (z >> MixShiftA)) * MixMul1;
    z = (z ^ (z >> MixShiftB)) * MixMul2;
    return z ^ (z >> MixShiftC);
  endfunction

  // One xorshift128+ draw: returns the sum of the two words as they stood,
  // then steps the model state.
  function automatic logic [WordW-1:0] xorshift_draw();
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] sum;
    a   = model_word0;
    b   = model_word1;
    sum = a + b;
    model_word0 = b;
    a = a ^ (a << XsShiftA);
    model_word1 = a ^ b ^ (a >> XsShiftB) ^ (b >> XsShiftC);
    return sum;
  endfunction

  // Applies one item to the model state and returns the result it must produce.
  function automatic gen_result_t predict_result(input gen_item_t it);
    gen_result_t      res;
    logic [WordW-1:0] sum;
    res.value = '0;
    res.error = 1'b0;
    case (it.kind)
      KIND_DRAW64: begin
        res.value = xorshift_draw();
      end
      KIND_DRAW32: begin
        sum       = xorshift_draw();
        res.value = {{(WordW-HalfW){1'b0}}, sum[HalfW-1:0]};
      end
      KIND_SEED: begin
        // The counter advances by the gamma constant before each output.
        model_word0 = splitmix_scramble(it.seed + MixGamma);
        model_word1 = splitmix_scramble(it.seed + MixGamma + MixGamma);
      end
      default: begin
        // A load always takes effect; an all-zero pair is flagged.
        model_word0 = it.word0;
        model_word1 = it.word1;
        res.error   = (it.word0 == '0) && (it.word1 == '0);
      end
    endcase
    return res;
  endfunction

  // Random item: mostly draws, so the state runs long stretches between
  // reseeds, with seeds and loads mixed in. Loads sometimes carry a zero word
  // or the all-zero pair that raises the error flag.
  function automatic gen_item_t random_item();
    gen_item_t   it;
    int unsigned pick;
    pick     = $urandom_range(99);
    it.seed  = {$urandom, $urandom};
    it.word0 = {$urandom, $urandom};
    it.word1 = {$urandom, $urandom};
    if (pick < 45) begin
      it.kind = KIND_DRAW64;
    end else if (pick < 80) begin
      it.kind = KIND_DRAW32;
    end else if (pick < 90) begin
      it.kind = KIND_SEED;
    end else begin
      it.kind = KIND_LOAD;
    end
    if (it.kind == KIND_LOAD) begin
      case ($urandom_range(7))
        0: begin
          it.word0 = '0;
          it.word1 = '0;
        end
        1: it.word0 = '0;
        2: it.word1 = '0;
        default: ;
      endcase
    end
    return it;
  endfunction

  // Offers one item on the input channel. It is entered right after a rising
  // edge with no item pending, and returns right after the edge that accepted
  // the item, with valid still high. So each call makes exactly one assignment
  // to valid per edge: either it lowers valid for a gap, or it raises it with
  // the new payload.
  task automatic send_item(input gen_item_t it, input gen_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= it.kind;
    seed_i       <= it.seed;
    load_word0_i <= it.word0;
    load_word1_i <= it.word1;
    pending_results.push_back(want);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Holds the sender off until every outstanding result has come back.
  // At least one edge always passes, so valid is never lowered and raised
  // again in the same time step.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // The receiver stalls at random, at the rate the current phase asks for.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker and activity counter for the watchdog. Everything here
  // reads the values that stood just before the edge, since both the block and
  // the drivers update with nonblocking assignments.
  always @(posedge clk_i) begin
    gen_result_t want;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with none expected: expected nothing, actual value %h error %b",
                 $time, value_o, error_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (value_o !== want.value) begin
          $display("%0t ns: value mismatch: expected %h, actual %h", $time, want.value, value_o);
          mismatch_count++;
        end
        if (error_o !== want.error) begin
          $display("%0t ns: error mismatch: expected %b, actual %b", $time, want.error, error_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a run in which nothing moves on either channel for too long has
  // hung. The limit covers a seed plus many cycles of receiver stall.
  initial begin
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("%0t ns: no item moved on either channel for %0d cycles", $time, StallLimit);
    $display("xorshift128plus_prng_splitmix_seed_top verification failed");
    $finish;
  end

  initial begin
    directed_row_t directed_rows [DirectedRows];
    gen_item_t     item;
    gen_result_t   want;

    // Directed rows. The first ones run from reset, where the state is zero
    // and every draw gives zero. Then come the all-zero load that raises the
    // error flag, all-ones words, seeds at both extremes and back to back, and
    // loads with one word zero. Unused fields carry extreme values to show
    // that they are ignored.
    directed_rows = '{
      '{'{KIND_DRAW64, '0, '0, '0},                   1'b1, '{'0, 1'b0}},
      '{'{KIND_DRAW32, AllOnes, AllOnes, AllOnes},    1'b1, '{'0, 1'b0}},
      '{'{KIND_LOAD,   AllOnes, '0, '0},              1'b1, '{'0, 1'b1}},
      '{'{KIND_DRAW64, AllOnes, AllOnes, AllOnes},    1'b1, '{'0, 1'b0}},
      '{'{KIND_LOAD,   '0, AllOnes, AllOnes},         1'b1, '{'0, 1'b0}},
      '{'{KIND_DRAW64, '0, '0, '0},                   1'b1,
        '{64'hffff_ffff_ffff_fffe, 1'b0}},
      '{'{KIND_DRAW32, '0, '0, '0},                   1'b0, '{'0, 1'b0}},
      '{'{KIND_DRAW64, '0, '0, '0},                   1'b0, '{'0, 1'b0}},
      '{'{KIND_SEED,   '0, AllOnes, AllOnes},         1'b1, '{'0, 1'b0}},
      '{'{KIND_DRAW64, '0, '0, '0},                   1'b0, '{'0, 1'b0}},
      '{'{KIND_DRAW32, '0, '0, '0},                   1'b0, '{'0, 1'b0}},
      '{'{KIND_SEED,   AllOnes, '0, '0},              1'b1, '{'0, 1'b0}},
      '{'{KIND_DRAW64, '0, '0, '0},                   1'b0, '{'0, 1'b0}},
      '{'{KIND_DRAW32, '0, '0, '0},                   1'b0, '{'0, 1'b0}},
      '{'{KIND_LOAD,   '0, 64'h1, '0},                1'b1, '{'0, 1'b0}},
      '{'{KIND_DRAW64, '0, '0, '0},                   1'b1, '{64'h1, 1'b0}},
      '{'{KIND_DRAW64, '0, '0, '0},                   1'b0, '{'0, 1'b0}},
      '{'{KIND_LOAD,   '0, '0, TopBit},               1'b1, '{'0, 1'b0}},
      '{'{KIND_DRAW32, '0, '0, '0},                   1'b0, '{'0, 1'b0}},
      '{'{KIND_DRAW64, '0, '0, '0},                   1'b0, '{'0, 1'b0}},
      '{'{KIND_SEED,   TopBit, '0, '0},               1'b1, '{'0, 1'b0}},
      '{'{KIND_SEED,   64'h0123_4567_89ab_cdef, '0, '0}, 1'b1, '{'0, 1'b0}},
      '{'{KIND_DRAW64, '0, '0, '0},                   1'b0, '{'0, 1'b0}},
      '{'{KIND_LOAD,   '0, AllOnes, '0},              1'b1, '{'0, 1'b0}},
      '{'{KIND_DRAW32, '0, '0, '0},                   1'b1,
        '{64'h0000_0000_ffff_ffff, 1'b0}}
    };

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The model is stepped for every row so its state follows the block; typed
    // rows then replace the computed expectation with the one in the table.
    foreach (directed_rows[i]) begin
      item = directed_rows[i].item;
      want = predict_result(item);
      if (directed_rows[i].typed) begin
        want = directed_rows[i].result;
      end
      send_item(item, want);
    end
    wait_results_drained();

    // Random part in three phases: sender idles less than the receiver, then
    // the reverse, then both at full rate. Between phases the sender waits for
    // the block to drain, which also exercises a fully idle pipeline.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        item = random_item();
        want = predict_result(item);
        send_item(item, want);
      end
      wait_results_drained();
    end

    // Quiet period to catch any stray result after the last expected one.
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("xorshift128plus_prng_splitmix_seed_top verification clean");
    end else begin
      $display("xorshift128plus_prng_splitmix_seed_top verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/xsp_pkg.sv
rtl/core/xsp_mul.sv
rtl/core/xorshift128plus_prng_splitmix_seed_top.sv
tb/sv/xorshift128plus_prng_splitmix_seed_top_test.sv
